// ----- rtl/nsf_pkg.sv -----
// nsf_pkg: shared types, codes and a helper function for the NMEA sentence framer.
// Used by nsf_front, nsf_queue, nsf_back and nmea_sentence_framer; no dependencies.
`timescale 1ns / 1ps

package nsf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SUM_W    = 7;
    localparam int unsigned FIDX_W   = 6;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_A = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_B = 8'd1;

    localparam logic [BYTE_W-1:0] START_A_RST = 8'd36;
    localparam logic [BYTE_W-1:0] START_B_RST = 8'd33;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'd44;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'd42;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'd65;
    localparam logic [BYTE_W-1:0] CH_UP_F  = 8'd70;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_HEX_OFS = 8'd87;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'd32;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_CSUM = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_NO_STAR   = 2'd2,
        ST_BAD_START = 2'd3
    } status_t;

    typedef struct packed {
        logic is_eol;
        logic is_comma;
        logic is_star;
        logic is_space;
        logic is_start;
    } cls_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] lc;
        cls_t              cls;
    } qent_t;

    // lowercase ASCII hex digit for a nibble
    function automatic logic [BYTE_W-1:0] hex_lower(input logic [3:0] nib);
        logic [BYTE_W-1:0] r;
        if (nib < 4'd10)
            r = CH_ZERO + {4'd0, nib};
        else
            r = CH_HEX_OFS + {4'd0, nib};
        return r;
    endfunction

endpackage

// ----- rtl/nmea_sentence_framer.sv -----
// NMEA-0183 sentence framer and checksum checker, one byte per word.
// The byte is written to the queue at the accepting edge; the back end registers its result
// word when it pops the entry, which waits while an unaccepted result word is held.
// Throughput: one byte per cycle while out_ready is high or the output register is empty.
// Reset: sentence state idle, checksum and field count zero, queue and output empty,
// start characters '$' and '!'.
`timescale 1ns / 1ps

module nmea_sentence_framer #(
    parameter int unsigned MAX_FIELDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsf_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [nsf_pkg::BYTE_W-1:0]    byte_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nsf_pkg::BYTE_W-1:0]    char_out,
    output logic [nsf_pkg::FIDX_W-1:0]    field_index,
    output logic                          field_char,
    output logic                          field_end,
    output logic                          report,
    output logic [1:0]                    status,
    output logic [nsf_pkg::SUM_W-1:0]     sum_out
);

    nsf_pkg::qent_t front_ent;
    nsf_pkg::qent_t back_ent;
    logic           q_not_full;
    logic           q_not_empty;
    logic           q_pop;

    assign in_ready = q_not_full;

    nsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_in   (byte_in),
        .ent       (front_ent)
    );

    nsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && q_not_full),
        .push_ent  (front_ent),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_ent   (back_ent)
    );

    nsf_back #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_ent       (back_ent),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .field_index (field_index),
        .field_char  (field_char),
        .field_end   (field_end),
        .report      (report),
        .status      (status),
        .sum_out     (sum_out)
    );

endmodule

// ----- rtl/nsf_front.sv -----
// nsf_front: holds the start-character registers and classifies each input byte.
// Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsf_pkg::BYTE_W-1:0]    cfg_data,
    input  logic [nsf_pkg::BYTE_W-1:0]    byte_in,
    output nsf_pkg::qent_t                ent
);

    logic [nsf_pkg::BYTE_W-1:0] start_a_reg;
    logic [nsf_pkg::BYTE_W-1:0] start_a_next;
    logic [nsf_pkg::BYTE_W-1:0] start_b_reg;
    logic [nsf_pkg::BYTE_W-1:0] start_b_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        start_a_next = start_a_reg;
        start_b_next = start_b_reg;
        if (cfg_valid)
        begin
            if (cfg_index == nsf_pkg::CFG_START_A)
                start_a_next = cfg_data;
            else if (cfg_index == nsf_pkg::CFG_START_B)
                start_b_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_a_reg <= nsf_pkg::START_A_RST;
            start_b_reg <= nsf_pkg::START_B_RST;
        end
        else
        begin
            start_a_reg <= start_a_next;
            start_b_reg <= start_b_next;
        end
    end

    always_comb
    begin
        ent.ch           = byte_in;
        ent.cls.is_eol   = (byte_in == nsf_pkg::CH_LF) || (byte_in == nsf_pkg::CH_CR);
        ent.cls.is_comma = (byte_in == nsf_pkg::CH_COMMA);
        ent.cls.is_star  = (byte_in == nsf_pkg::CH_STAR);
        ent.cls.is_space = (byte_in == nsf_pkg::CH_SPACE)
                        || ((byte_in >= nsf_pkg::CH_TAB) && (byte_in <= nsf_pkg::CH_CR));
        ent.cls.is_start = (byte_in == start_a_reg) || (byte_in == start_b_reg);
        // fold 'A'..'F' only
        if ((byte_in >= nsf_pkg::CH_UP_A) && (byte_in <= nsf_pkg::CH_UP_F))
            ent.lc = byte_in + nsf_pkg::CASE_OFS;
        else
            ent.lc = byte_in;
    end

endmodule

// ----- rtl/nsf_queue.sv -----
// nsf_queue: two-entry queue of classified words between front and back.
// Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nsf_pkg::qent_t push_ent,
    output logic           not_full,
    input  logic           pop,
    output logic           not_empty,
    output nsf_pkg::qent_t pop_ent
);

    nsf_pkg::qent_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_ent   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/nsf_back.sv -----
// nsf_back: sentence state machine, checksum and field tracking, output register.
// Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_back #(
    parameter int unsigned MAX_FIELDS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  nsf_pkg::qent_t             q_ent,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [nsf_pkg::BYTE_W-1:0] char_out,
    output logic [nsf_pkg::FIDX_W-1:0] field_index,
    output logic                       field_char,
    output logic                       field_end,
    output logic                       report,
    output logic [1:0]                 status,
    output logic [nsf_pkg::SUM_W-1:0]  sum_out
);

    localparam int unsigned FIELD_LIMIT_I = (MAX_FIELDS - 1 > 63) ? 63 : MAX_FIELDS - 1;
    localparam logic [nsf_pkg::FIDX_W-1:0] FIELD_LIMIT = FIELD_LIMIT_I[nsf_pkg::FIDX_W-1:0];

    nsf_pkg::phase_t                phase_reg;
    nsf_pkg::phase_t                phase_next;
    logic [nsf_pkg::SUM_W-1:0]      running_sum_reg;
    logic [nsf_pkg::SUM_W-1:0]      running_sum_next;
    logic [nsf_pkg::FIDX_W-1:0]     field_count_reg;
    logic [nsf_pkg::FIDX_W-1:0]     field_count_next;
    logic                           star_seen_reg;
    logic                           star_seen_next;
    logic [1:0]                     digit_count_reg;
    logic [1:0]                     digit_count_next;
    logic                           digit_mismatch_reg;
    logic                           digit_mismatch_next;
    logic [nsf_pkg::SUM_W-1:0]      frozen_sum_reg;
    logic [nsf_pkg::SUM_W-1:0]      frozen_sum_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [nsf_pkg::BYTE_W-1:0]     char_reg;
    logic [nsf_pkg::FIDX_W-1:0]     fidx_reg;
    logic [nsf_pkg::FIDX_W-1:0]     fidx_next;
    logic                           fchar_reg;
    logic                           fchar_next;
    logic                           fend_reg;
    logic                           fend_next;
    logic                           rep_reg;
    logic                           rep_next;
    nsf_pkg::status_t               status_reg;
    nsf_pkg::status_t               status_next;
    logic [nsf_pkg::SUM_W-1:0]      sum_reg;
    logic [nsf_pkg::SUM_W-1:0]      sum_next;

    logic [nsf_pkg::SUM_W-1:0]      sum_body;
    logic [nsf_pkg::SUM_W-1:0]      sum_held;
    logic [nsf_pkg::BYTE_W-1:0]     expect_ch;
    logic                           digit_ok;

    assign q_pop    = q_valid && (!out_valid_reg || out_ready);
    assign sum_body = running_sum_reg ^ q_ent.ch[nsf_pkg::SUM_W-1:0];
    assign sum_held = star_seen_reg ? frozen_sum_reg : sum_body;

    always_comb
    begin
        expect_ch = '0;
        digit_ok  = 1'b0;
        if (digit_count_reg == 2'd0)
        begin
            expect_ch = nsf_pkg::hex_lower({1'b0, frozen_sum_reg[6:4]});
            digit_ok  = (q_ent.lc == expect_ch);
        end
        else if (digit_count_reg == 2'd1)
        begin
            expect_ch = nsf_pkg::hex_lower(frozen_sum_reg[3:0]);
            digit_ok  = (q_ent.lc == expect_ch);
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (q_pop)
        begin
            unique case (phase_reg)
                nsf_pkg::PH_IDLE:
                begin
                    if (!q_ent.cls.is_space && q_ent.cls.is_start)
                        phase_next = nsf_pkg::PH_BODY;
                end
                nsf_pkg::PH_BODY, nsf_pkg::PH_CSUM:
                begin
                    priority if (q_ent.cls.is_eol)
                        phase_next = nsf_pkg::PH_IDLE;
                    else if (q_ent.cls.is_comma)
                        phase_next = nsf_pkg::PH_BODY;
                    else if (phase_reg == nsf_pkg::PH_BODY && !star_seen_reg
                             && q_ent.cls.is_star)
                        phase_next = nsf_pkg::PH_CSUM;
                    else
                        phase_next = phase_reg;
                end
                default:
                    phase_next = nsf_pkg::PH_IDLE;
            endcase
        end
    end

    // datapath and result word
    always_comb
    begin
        running_sum_next    = running_sum_reg;
        field_count_next    = field_count_reg;
        star_seen_next      = star_seen_reg;
        digit_count_next    = digit_count_reg;
        digit_mismatch_next = digit_mismatch_reg;
        frozen_sum_next     = frozen_sum_reg;
        fidx_next           = '0;
        fchar_next          = 1'b0;
        fend_next           = 1'b0;
        rep_next            = 1'b0;
        status_next         = nsf_pkg::ST_OK;
        sum_next            = '0;
        if (q_pop)
        begin
            unique case (phase_reg)
                nsf_pkg::PH_IDLE:
                begin
                    priority if (q_ent.cls.is_space)
                    begin
                        // skip
                    end
                    else if (q_ent.cls.is_start)
                    begin
                        running_sum_next    = '0;
                        field_count_next    = '0;
                        star_seen_next      = 1'b0;
                        digit_count_next    = 2'd0;
                        digit_mismatch_next = 1'b0;
                        frozen_sum_next     = '0;
                    end
                    else
                    begin
                        rep_next    = 1'b1;
                        status_next = nsf_pkg::ST_BAD_START;
                    end
                end
                nsf_pkg::PH_BODY, nsf_pkg::PH_CSUM:
                begin
                    fidx_next = field_count_reg;
                    priority if (q_ent.cls.is_eol)
                    begin
                        fend_next = 1'b1;
                        rep_next  = 1'b1;
                        if (!star_seen_reg)
                            status_next = nsf_pkg::ST_NO_STAR;
                        else if (digit_count_reg == 2'd2 && !digit_mismatch_reg)
                            status_next = nsf_pkg::ST_OK;
                        else
                            status_next = nsf_pkg::ST_MISMATCH;
                        sum_next = star_seen_reg ? frozen_sum_reg : running_sum_reg;
                    end
                    else if (q_ent.cls.is_comma)
                    begin
                        if (!star_seen_reg)
                            running_sum_next = sum_body;
                        fend_next = 1'b1;
                        if (field_count_reg < FIELD_LIMIT)
                            field_count_next = field_count_reg + 6'd1;
                        sum_next = sum_held;
                    end
                    else if (phase_reg == nsf_pkg::PH_CSUM)
                    begin
                        if (!digit_ok)
                            digit_mismatch_next = 1'b1;
                        if (digit_count_reg != 2'd3)
                            digit_count_next = digit_count_reg + 2'd1;
                        sum_next = frozen_sum_reg;
                    end
                    else if (!star_seen_reg && q_ent.cls.is_star)
                    begin
                        // freeze the checksum
                        star_seen_next      = 1'b1;
                        frozen_sum_next     = running_sum_reg;
                        digit_count_next    = 2'd0;
                        digit_mismatch_next = 1'b0;
                        sum_next            = running_sum_reg;
                    end
                    else
                    begin
                        fchar_next = 1'b1;
                        if (!star_seen_reg)
                            running_sum_next = sum_body;
                        sum_next = sum_held;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (q_pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= nsf_pkg::PH_IDLE;
            running_sum_reg    <= '0;
            field_count_reg    <= '0;
            star_seen_reg      <= 1'b0;
            digit_count_reg    <= 2'd0;
            digit_mismatch_reg <= 1'b0;
            frozen_sum_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            running_sum_reg    <= running_sum_next;
            field_count_reg    <= field_count_next;
            star_seen_reg      <= star_seen_next;
            digit_count_reg    <= digit_count_next;
            digit_mismatch_reg <= digit_mismatch_next;
            frozen_sum_reg     <= frozen_sum_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // result payload, loaded on pop
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            char_reg   <= q_ent.ch;
            fidx_reg   <= fidx_next;
            fchar_reg  <= fchar_next;
            fend_reg   <= fend_next;
            rep_reg    <= rep_next;
            status_reg <= status_next;
            sum_reg    <= sum_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_reg;
    assign field_index = fidx_reg;
    assign field_char  = fchar_reg;
    assign field_end   = fend_reg;
    assign report      = rep_reg;
    assign status      = status_reg;
    assign sum_out     = sum_reg;

endmodule
